// ===== rtl/tts_pkg.sv =====
// Shared types and constants for the two-trigger servo pattern sequencer.
// No dependencies; compile first.
package tts_pkg;

  localparam int PATTERN_LENGTH_DEF = 4;
  localparam int POS_W              = 16;
  localparam int COUNT_W            = 16;
  localparam int REPEAT_W           = 8;
  localparam int PATTERN_W          = 64;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_INDEX_W        = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_POSITIONS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_REPEAT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_REPEAT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_PAUSE       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_PAUSE        = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FRING  = 3'd1,
    PH_FPAUSE = 3'd2,
    PH_FREP   = 3'd3,
    PH_BRING  = 3'd4,
    PH_BPAUSE = 3'd5,
    PH_BREP   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_positions;
    logic [REPEAT_W-1:0]  front_ring_reps;
    logic [REPEAT_W-1:0]  back_ring_reps;
    logic [COUNT_W-1:0]   front_pause_ticks;
    logic [COUNT_W-1:0]   back_pause_ticks;
  } cfg_t;

endpackage

// ===== rtl/tts_if.sv =====
// Valid/ready channel interfaces for tick input and position result.
// Depends on tts_pkg.
interface tts_tick_if;
  logic valid;
  logic ready;
  logic front_pressed;
  logic back_pressed;

  modport source (output valid, front_pressed, back_pressed, input ready);
  modport sink   (input valid, front_pressed, back_pressed, output ready);
endinterface

interface tts_result_if import tts_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] servo_position;
  logic [2:0]              phase;

  modport source (output valid, servo_position, phase, input ready);
  modport sink   (input valid, servo_position, phase, output ready);
endinterface

// ===== rtl/tts_cfg.sv =====
// Configuration register file written through the plain write port.
// Depends on tts_pkg.
module tts_cfg import tts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_positions <= '0;
      cfg.front_ring_reps   <= REPEAT_W'(1);
      cfg.back_ring_reps    <= REPEAT_W'(1);
      cfg.front_pause_ticks <= COUNT_W'(50);
      cfg.back_pause_ticks  <= COUNT_W'(50);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_POSITIONS: cfg.pattern_positions <= cfg_data[PATTERN_W-1:0];
        REG_FRONT_REPEAT:      cfg.front_ring_reps   <= cfg_data[REPEAT_W-1:0];
        REG_BACK_REPEAT:       cfg.back_ring_reps    <= cfg_data[REPEAT_W-1:0];
        REG_FRONT_PAUSE:       cfg.front_pause_ticks <= cfg_data[COUNT_W-1:0];
        REG_BACK_PAUSE:        cfg.back_pause_ticks  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tts_core.sv =====
// Sequencer state (phase, countdown, pattern index, held position) and its
// per-tick update. Depends on tts_pkg.
module tts_core import tts_pkg::*; #(
  parameter int PATTERN_LENGTH = PATTERN_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             front_pressed,
  input  logic             back_pressed,
  input  cfg_t             cfg,
  output logic [POS_W-1:0] position_next,
  output phase_t           phase_next
);

  localparam int IDX_W = (PATTERN_LENGTH > 2) ? $clog2(PATTERN_LENGTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PATTERN_LENGTH - 1);

  phase_t             phase_reg;
  logic [COUNT_W-1:0] countdown, countdown_next, count_dec;
  logic [IDX_W-1:0]   pattern_index, pattern_index_next;
  logic [POS_W-1:0]   held_position;
  logic [COUNT_W-1:0] front_ring_len, back_ring_len;
  logic               ring;

  assign front_ring_len = COUNT_W'(PATTERN_LENGTH) * COUNT_W'(cfg.front_ring_reps);
  assign back_ring_len  = COUNT_W'(PATTERN_LENGTH) * COUNT_W'(cfg.back_ring_reps);
  assign count_dec      = (countdown != '0) ? countdown - COUNT_W'(1) : countdown;

  // phase and countdown
  always_comb begin
    phase_next     = phase_reg;
    countdown_next = count_dec;
    if (phase_reg == PH_IDLE) begin
      if (front_pressed) begin
        phase_next     = PH_FRING;
        countdown_next = front_ring_len;
      end else if (back_pressed) begin
        phase_next     = PH_BRING;
        countdown_next = back_ring_len;
      end
    end else if (count_dec == '0) begin
      unique case (phase_reg)
        PH_FRING: begin
          phase_next     = PH_FPAUSE;
          countdown_next = cfg.front_pause_ticks;
        end
        PH_FPAUSE: begin
          phase_next     = PH_FREP;
          countdown_next = front_ring_len;
        end
        PH_BRING: begin
          phase_next     = PH_BPAUSE;
          countdown_next = cfg.back_pause_ticks;
        end
        PH_BPAUSE: begin
          phase_next     = PH_BREP;
          countdown_next = back_ring_len;
        end
        default: begin
          phase_next     = PH_IDLE;
          countdown_next = '0;
        end
      endcase
    end
  end

  // sampling: never on the demand tick; index kept across the repeat ring
  always_comb begin
    ring = (phase_next == PH_FRING) || (phase_next == PH_FREP) ||
           (phase_next == PH_BRING) || (phase_next == PH_BREP);
    position_next      = held_position;
    pattern_index_next = pattern_index;
    if (phase_reg == PH_IDLE) begin
      pattern_index_next = '0;
    end else if (ring) begin
      position_next      = cfg.pattern_positions[POS_W*pattern_index +: POS_W];
      pattern_index_next = (pattern_index == IDX_LAST) ? '0 : pattern_index + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      countdown     <= '0;
      pattern_index <= '0;
      held_position <= '0;
    end else if (advance) begin
      phase_reg     <= phase_next;
      countdown     <= countdown_next;
      pattern_index <= pattern_index_next;
      held_position <= position_next;
    end
  end

  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_IDLE |-> countdown == '0)
    else $error("countdown nonzero while idle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    pattern_index <= IDX_LAST)
    else $error("pattern index out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase_reg) && $stable(countdown) && $stable(held_position))
    else $error("state changed without a tick");

endmodule

// ===== rtl/two_trigger_servo_pattern_sequencer.sv =====
// Top level of the two-trigger servo pattern sequencer.
// Depends on tts_pkg, tts_if, tts_cfg and tts_core.
//
// Usage:
//   tick    : one transaction per control tick, carrying the front and rear
//             press flags.
//   result  : one transaction per tick, the held servo position code and the
//             phase after that tick.
//   cfg_*   : register writes (pattern, repeats, pauses), applied at the edge
//             where cfg_write is high; write only while no tick is in flight.
// Latency: the result of a tick is presented the cycle after it is taken.
// Throughput: one tick per cycle while results are drained; the state update is
//   a decrement, a few compares and a pattern mux between the state registers and
//   the result register.
// A tick is taken whenever the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the pending result and blocks
// only further ticks.
// Reset (rst, synchronous) returns to idle with position 0 and loads the
// register defaults: pattern 0, repeats 1, pauses 50.
module two_trigger_servo_pattern_sequencer import tts_pkg::*; #(
  parameter int PATTERN_LENGTH = PATTERN_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  tts_tick_if.sink               tick,
  tts_result_if.source           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t             cfg;
  logic             accept;
  logic [POS_W-1:0] position_next;
  phase_t           phase_next;

  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  tts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tts_core #(.PATTERN_LENGTH(PATTERN_LENGTH)) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .front_pressed (tick.front_pressed),
    .back_pressed  (tick.back_pressed),
    .cfg           (cfg),
    .position_next (position_next),
    .phase_next    (phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.servo_position <= $signed(position_next);
      result.phase          <= phase_next;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted tick produced no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !tick.ready)
    else $error("tick taken while result stalled");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=>
      result.valid && $stable(result.servo_position) && $stable(result.phase))
    else $error("stalled result changed");

endmodule

// ===== dv/two_trigger_servo_pattern_sequencer_tb.sv =====
// Self-checking testbench for two_trigger_servo_pattern_sequencer: tick and result
// channels with random idling, register writes between runs, in-bench sequencer model.
// Depends on tts_pkg, tts_if and the RTL top level.
`timescale 1ns / 1ps
module two_trigger_servo_pattern_sequencer_tb;
  import tts_pkg::*;

  localparam int PLEN        = PATTERN_LENGTH_DEF;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic front;
    logic back;
  } tick_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    phase_t           phase;
  } servo_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tts_tick_if   tick_ch ();
  tts_result_if result_ch ();

  two_trigger_servo_pattern_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the registers and state
  logic [PATTERN_W-1:0] m_pattern;
  logic [REPEAT_W-1:0]  m_front_rep;
  logic [REPEAT_W-1:0]  m_back_rep;
  logic [COUNT_W-1:0]   m_front_pause;
  logic [COUNT_W-1:0]   m_back_pause;
  phase_t               m_phase;
  logic [COUNT_W-1:0]   m_count;
  logic [1:0]           m_index;
  logic [POS_W-1:0]     m_held;

  tick_t      tick_q[$];
  servo_out_t servo_expect_q[$];

  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       errors = 0;
  int       results_checked = 0;
  int       settings_run = 0;
  int       quiet_cycles = 0;
  logic [7:0] phases_seen = '0;

  function automatic logic [COUNT_W-1:0] ring_ticks(input logic [REPEAT_W-1:0] rep);
    return COUNT_W'(PLEN * int'(rep));
  endfunction

  function automatic servo_out_t sequencer_step(input tick_t t);
    servo_out_t r;
    if (m_count != 0) m_count = m_count - 1'b1;
    if (m_phase == PH_IDLE) begin
      m_index = '0;
      if (t.front) begin
        m_phase = PH_FRING;
        m_count = ring_ticks(m_front_rep);
      end else if (t.back) begin
        m_phase = PH_BRING;
        m_count = ring_ticks(m_back_rep);
      end
    end else begin
      if (m_count == 0) begin
        case (m_phase)
          PH_FRING: begin
            m_phase = PH_FPAUSE;
            m_count = m_front_pause;
          end
          PH_FPAUSE: begin
            m_phase = PH_FREP;
            m_count = ring_ticks(m_front_rep);
          end
          PH_BRING: begin
            m_phase = PH_BPAUSE;
            m_count = m_back_pause;
          end
          PH_BPAUSE: begin
            m_phase = PH_BREP;
            m_count = ring_ticks(m_back_rep);
          end
          default: begin
            m_phase = PH_IDLE;
            m_count = '0;
          end
        endcase
      end
      // index keeps running into the repeat ring
      if (m_phase inside {PH_FRING, PH_FREP, PH_BRING, PH_BREP}) begin
        m_held  = m_pattern[POS_W*m_index +: POS_W];
        m_index = (int'(m_index) + 1 >= PLEN) ? 2'd0 : m_index + 1'b1;
      end
    end
    r.position = m_held;
    r.phase    = m_phase;
    return r;
  endfunction

  // tick driver
  always @(posedge clk) begin : tick_drive
    tick_t nxt;
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || tick_ch.ready) begin
      if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = tick_q.pop_front();
        tick_ch.valid         <= 1'b1;
        tick_ch.front_pressed <= nxt.front;
        tick_ch.back_pressed  <= nxt.back;
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin : result_mon
    servo_out_t want;
    logic       moved;
    moved = 1'b0;
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) begin
        servo_expect_q.push_back(sequencer_step(tick_t'({tick_ch.front_pressed,
                                                         tick_ch.back_pressed})));
        moved = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        results_checked++;
        if (!$isunknown(result_ch.phase)) phases_seen[result_ch.phase] = 1'b1;
        if (servo_expect_q.size() == 0) begin
          $error("result transaction with no tick waiting for it");
          errors++;
        end else begin
          want = servo_expect_q.pop_front();
          if (result_ch.servo_position !== want.position) begin
            $error("servo_position: expected %0d, got %0d",
                   $signed(want.position), result_ch.servo_position);
            errors++;
          end
          if (result_ch.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, result_ch.phase);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || tick_ch.valid || servo_expect_q.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_POSITIONS: m_pattern     = val[PATTERN_W-1:0];
      REG_FRONT_REPEAT:      m_front_rep   = val[REPEAT_W-1:0];
      REG_BACK_REPEAT:       m_back_rep    = val[REPEAT_W-1:0];
      REG_FRONT_PAUSE:       m_front_pause = val[COUNT_W-1:0];
      REG_BACK_PAUSE:        m_back_pause  = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [PATTERN_W-1:0] pat,
                               input logic [REPEAT_W-1:0] fr, input logic [REPEAT_W-1:0] br,
                               input logic [COUNT_W-1:0] fp, input logic [COUNT_W-1:0] bp);
    drain();
    write_reg(REG_PATTERN_POSITIONS, CFG_DATA_W'(pat));
    write_reg(REG_FRONT_REPEAT, CFG_DATA_W'(fr));
    write_reg(REG_BACK_REPEAT, CFG_DATA_W'(br));
    write_reg(REG_FRONT_PAUSE, CFG_DATA_W'(fp));
    write_reg(REG_BACK_PAUSE, CFG_DATA_W'(bp));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_run++;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic push_tick(input logic f, input logic b, input int reps);
    tick_t t;
    t.front = f;
    t.back  = b;
    repeat (reps) tick_q.push_back(t);
  endtask

  // presses are frequent enough that idle stretches end quickly
  task automatic push_random_ticks(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      push_tick(r < 15 || (r >= 30 && r < 38), r >= 15 && r < 38, 1);
    end
  endtask

  function automatic logic [PATTERN_W-1:0] rand_pattern();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    tick_ch.valid         = 1'b0;
    tick_ch.front_pressed = 1'b0;
    tick_ch.back_pressed  = 1'b0;
    result_ch.ready       = 1'b0;
    m_pattern     = '0;
    m_front_rep   = 8'd1;
    m_back_rep    = 8'd1;
    m_front_pause = 16'd50;
    m_back_pause  = 16'd50;
    m_phase       = PH_IDLE;
    m_count       = '0;
    m_index       = '0;
    m_held        = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    set_idling(10, 73);
    push_tick(1'b1, 1'b0, 1);
    push_tick(1'b0, 1'b0, 2);

    // extreme position codes; front ring, zero pause, repeat ring, back to idle,
    // then both pressed (front wins), then a rear start
    load_settings(64'h8000_7FFF_FFFF_0000, 8'd1, 8'd2, 16'd0, 16'd1);
    push_tick(1'b1, 1'b0, 1);
    push_tick(1'b0, 1'b0, 9);
    push_tick(1'b1, 1'b1, 1);
    push_tick(1'b0, 1'b0, 9);
    push_tick(1'b0, 1'b1, 1);
    push_tick(1'b0, 1'b0, 4);

    load_settings(rand_pattern(), 8'd1, 8'd1, 16'd0, 16'd0);
    push_random_ticks(350);
    // zero front repeat: first ring ends with no sample, repeat ring after a single sample
    load_settings(rand_pattern(), 8'd0, 8'd3, 16'd2, 16'd5);
    push_random_ticks(350);

    set_idling(73, 10);
    load_settings(rand_pattern(), 8'd2, 8'd1, 16'd50, 16'd50);
    push_random_ticks(350);
    load_settings(rand_pattern(), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
    push_random_ticks(400);

    set_idling(0, 0);
    load_settings(rand_pattern(), 8'($urandom_range(1, 3)), 8'd2, 16'd1, 16'd3);
    push_random_ticks(300);
    // largest registers last: the block stays in a long ring from here on
    load_settings({PATTERN_W{1'b1}}, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    push_random_ticks(250);

    drain();
    repeat (3) @(negedge clk);
    $display("tb: %0d results checked over %0d register settings", results_checked,
             settings_run);
    $display("tb: phases observed (bit n = phase n): %b", phases_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tts_pkg.sv
rtl/tts_if.sv
rtl/tts_cfg.sv
rtl/tts_core.sv
rtl/two_trigger_servo_pattern_sequencer.sv
dv/two_trigger_servo_pattern_sequencer_tb.sv
